@@ rtl/deque_with_value_search_delete_defines.svh @@
// assertion macros shared by the deque rtl
// no dependencies; included by the files that carry assertions
`ifndef DEQUE_WITH_VALUE_SEARCH_DELETE_DEFINES_SVH
`define DEQUE_WITH_VALUE_SEARCH_DELETE_DEFINES_SVH

// property checked at every clock edge outside reset
`define DQS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication with the consequent checked in the next cycle
`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dqs_pkg.sv @@
// shared types and constants of the deque with value search and delete
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dqs_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int ACTION_W        = 3;
    localparam int IN_VALUE_W      = 32;
    localparam int COUNT_W         = 5;
    localparam int OUT_TDATA_W     = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR      = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_SEARCH     = 3'd5,
        ACT_DELETE     = 3'd6
    } t_action;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_SHIFT_LEFT,
        OP_MATCH,
        OP_SCAN,
        OP_DELETE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

@@ rtl/deque_with_value_search_delete.sv @@
// top level of the bounded deque with value search and delete
// depends on dqs_pkg, dqs_ctrl and dqs_cell
//
// channel   dir  handshake                    payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser action, tdata value
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata ok, count
//
// clear, push and pop act on the store when accepted; search and delete first
// compare every cell, then let the hit flag ripple down the cell chain one cell
// a cycle, then report and, for a delete, close the gap
// one request is in service at a time; a result left waiting in the output
// register holds off the next request, and a finished lookup waits while
// the output is stalled
// synchronous active-low reset empties the store; cell contents are kept
`timescale 1ns / 1ps

module deque_with_value_search_delete import dqs_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_VALUE_W-1:0]  i_s_axis_tdata,   // value
    input  logic [ACTION_W-1:0]    i_s_axis_tuser,   // action
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // ok, count, zero pad
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    t_cell_op               w_op;
    logic [FILL_W-1:0]      w_fill;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_data  [DEPTH];
    logic [VALUE_WIDTH-1:0] w_left  [DEPTH];
    logic [VALUE_WIDTH-1:0] w_right [DEPTH];
    logic                   w_seen  [DEPTH];
    logic                   w_seen_in [DEPTH];

    dqs_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .FILL_W      (FILL_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .i_found    (w_seen[DEPTH-1]),
        .o_op       (w_op),
        .o_fill     (w_fill),
        .o_value    (w_value)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // front cell takes the pushed value from the left
        if (g == 0) begin : g_front
            assign w_left[g]    = w_value;
            assign w_seen_in[g] = 1'b0;
        end else begin : g_inner
            assign w_left[g]    = w_data[g-1];
            assign w_seen_in[g] = w_seen[g-1];
        end
        if (g == DEPTH - 1) begin : g_back
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_data[g+1];
        end

        dqs_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .FILL_W      (FILL_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_fill  (w_fill),
            .i_value (w_value),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_seen  (w_seen_in[g]),
            .o_data  (w_data[g]),
            .o_seen  (w_seen[g])
        );
    end

endmodule

@@ rtl/dqs_cell.sv @@
// one storage cell of the deque chain: holds an element, its match flag
// and the running "match seen to the left" flag; depends on dqs_pkg
`timescale 1ns / 1ps

module dqs_cell import dqs_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FILL_W      = $clog2(DEPTH_DEF + 1),
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_op               i_op,
    input  logic [FILL_W-1:0]      i_fill,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic                   i_seen,
    output logic [VALUE_WIDTH-1:0] o_data,
    output logic                   o_seen
);

    localparam logic [FILL_W-1:0] MY_INDEX = FILL_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;
    logic                   r_match;
    logic                   n_match;
    logic                   r_seen;
    logic                   n_seen;
    logic                   w_occupied;

    assign w_occupied = (MY_INDEX < i_fill);

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        n_seen  = r_seen;
        case (i_op)
            OP_PUSH_FRONT: n_data = i_left;
            OP_PUSH_BACK: begin
                if (MY_INDEX == i_fill) begin
                    n_data = i_value;
                end
            end
            OP_SHIFT_LEFT: n_data = i_right;
            OP_MATCH: begin
                n_match = w_occupied && (r_data == i_value);
                n_seen  = 1'b0;
            end
            OP_SCAN: n_seen = i_seen;
            // this cell and all after the first hit close the gap
            OP_DELETE: begin
                if (r_seen || r_match) begin
                    n_data = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            r_match <= n_match;
            r_seen  <= n_seen;
        end
    end

    assign o_data = r_data;
    assign o_seen = r_seen || r_match;

endmodule

@@ rtl/dqs_ctrl.sv @@
// request sequencer of the deque: handshakes, fill count, scan timing
// and the result register; depends on dqs_pkg and the assertion macros
`timescale 1ns / 1ps
`include "deque_with_value_search_delete_defines.svh"

module dqs_ctrl import dqs_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FILL_W      = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_VALUE_W-1:0]  i_s_tdata,
    input  logic [ACTION_W-1:0]    i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_found,
    output t_cell_op               o_op,
    output logic [FILL_W-1:0]      o_fill,
    output logic [VALUE_WIDTH-1:0] o_value
);

    localparam int SCAN_W = $clog2(DEPTH);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DEPTH - 2);
    localparam logic [FILL_W-1:0] FULL      = FILL_W'(DEPTH);

    t_state                 r_state;
    t_state                 n_state;
    logic [SCAN_W-1:0]      r_scan_cnt;
    logic [SCAN_W-1:0]      n_scan_cnt;
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_is_delete;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   r_ok;
    logic                   n_ok;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;

    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    t_action                w_action;
    logic [VALUE_WIDTH-1:0] w_in_value;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_fill == FULL);
    assign w_empty    = (r_fill == '0);
    assign w_action   = t_action'(i_s_tuser);
    assign w_in_value = VALUE_WIDTH'($signed(i_s_tdata));

    // next state
    always_comb begin
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_scan_cnt = '0;
                if (w_accept && (w_action == ACT_SEARCH || w_action == ACT_DELETE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_scan_cnt = r_scan_cnt + 1'b1;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell commands, fill count and result
    always_comb begin
        o_op        = OP_HOLD;
        n_fill      = r_fill;
        n_ok        = r_ok;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ok = 1'b0;
                    case (w_action)
                        ACT_CLEAR: begin
                            n_fill = '0;
                            n_ok   = 1'b1;
                        end
                        ACT_PUSH_FRONT: begin
                            if (!w_full) begin
                                o_op   = OP_PUSH_FRONT;
                                n_fill = r_fill + 1'b1;
                                n_ok   = 1'b1;
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (!w_full) begin
                                o_op   = OP_PUSH_BACK;
                                n_fill = r_fill + 1'b1;
                                n_ok   = 1'b1;
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (!w_empty) begin
                                o_op   = OP_SHIFT_LEFT;
                                n_fill = r_fill - 1'b1;
                                n_ok   = 1'b1;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (!w_empty) begin
                                n_fill = r_fill - 1'b1;
                                n_ok   = 1'b1;
                            end
                        end
                        ACT_SEARCH, ACT_DELETE: o_op = OP_MATCH;
                        default: ;
                    endcase
                    // search and delete report after the scan
                    if (w_action != ACT_SEARCH && w_action != ACT_DELETE) begin
                        n_out_valid = 1'b1;
                        n_count     = COUNT_W'(n_fill);
                    end
                end
            end
            S_SCAN: o_op = OP_SCAN;
            S_FINISH: begin
                if (w_out_free) begin
                    n_ok        = i_found;
                    n_out_valid = 1'b1;
                    if (i_found && r_is_delete) begin
                        o_op   = OP_DELETE;
                        n_fill = r_fill - 1'b1;
                    end
                    n_count = COUNT_W'(n_fill);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_cnt  <= n_scan_cnt;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_count <= n_count;
        if (w_accept) begin
            r_value     <= w_in_value;
            r_is_delete <= (w_action == ACT_DELETE);
        end
    end

    assign o_fill     = r_fill;
    assign o_value    = (r_state == S_IDLE) ? w_in_value : r_value;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_count, r_ok});

    `DQS_ASSERT(a_fill_bound, r_fill <= FULL, "fill count beyond depth")
    `DQS_ASSERT(a_ready_idle, !o_s_tready || r_state == S_IDLE, "ready outside idle")
    `DQS_ASSERT_NEXT(a_lookup_scans,
        w_accept && (w_action == ACT_SEARCH || w_action == ACT_DELETE),
        r_state == S_SCAN && !o_m_tvalid, "lookup did not start a scan")
    `DQS_ASSERT_NEXT(a_clear_empties, w_accept && w_action == ACT_CLEAR,
        r_fill == '0 && o_m_tvalid, "clear left elements behind")

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the bounded deque with value search and delete
// depends on dqs_pkg and the deque_with_value_search_delete rtl; keeps its own deque model
`timescale 1ns / 1ps

module tb_top;
    import dqs_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int DRAIN_CYCLES = DEPTH_DEF + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } t_dq_result;

    logic                   clk;
    logic                   rst_n   = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_VALUE_W-1:0]  s_data  = '0;   // value
    logic [ACTION_W-1:0]    s_user  = '0;   // action
    logic                   m_ready = 1'b0;
    logic                   m_valid;
    logic                   s_ready;
    logic [OUT_TDATA_W-1:0] m_data;         // ok, count, zero pad

    // deque contents as the block should hold them, front at index 0
    logic [IN_VALUE_W-1:0] model_cells[$];
    t_dq_result            pending_results[$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_requested = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int stuck_cycles   = 0;

    deque_with_value_search_delete u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic t_dq_result apply_request(input logic [ACTION_W-1:0] act,
                                                 input logic [IN_VALUE_W-1:0] val);
        t_dq_result res;
        int         pos;
        res.ok = 1'b0;
        pos    = -1;
        case (act)
            ACT_CLEAR: begin
                model_cells.delete();
                res.ok = 1'b1;
            end
            ACT_PUSH_FRONT: begin
                if (model_cells.size() < DEPTH) begin
                    model_cells.push_front(val);
                    res.ok = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (model_cells.size() < DEPTH) begin
                    model_cells.push_back(val);
                    res.ok = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (model_cells.size() > 0) begin
                    void'(model_cells.pop_front());
                    res.ok = 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (model_cells.size() > 0) begin
                    void'(model_cells.pop_back());
                    res.ok = 1'b1;
                end
            end
            ACT_SEARCH, ACT_DELETE: begin
                for (int k = 0; k < model_cells.size(); k++) begin
                    if (pos < 0 && model_cells[k] == val)
                        pos = k;
                end
                if (pos >= 0) begin
                    res.ok = 1'b1;
                    // delete removes only the front-most match
                    if (act == ACT_DELETE)
                        model_cells.delete(pos);
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(model_cells.size());
        return res;
    endfunction

    // transaction monitor: checks results, then predicts for accepted requests
    always @(posedge clk) begin
        t_dq_result want;
        t_dq_result got;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                got.ok    = m_data[0];
                got.count = m_data[COUNT_W:1];
                if (pending_results.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected result: ok=%0d count=%0d", got.ok, got.count);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok || got.count !== want.count) begin
                        if (error_count < MAX_REPORTS)
                            $display("mismatch: expected ok=%0d count=%0d, got ok=%0d count=%0d",
                                     want.ok, want.count, got.ok, got.count);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(apply_request(s_user, s_data));
        end
    end

    // result sink with random stalls and an occasional long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_served != hold_requested) begin
                hold_served = hold_requested;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [IN_VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= val;
        s_user  <= act;
        do @(posedge clk); while (!s_ready);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IN_VALUE_W-1:0] pick_value();
        // a small pool keeps searches hitting and duplicates common
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h5A5A_A5A5;
            6:       return 32'h0000_0010;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input bit filling);
        int r;
        int push_w;
        int pop_w;
        r      = $urandom_range(99);
        push_w = filling ? 45 : 20;
        pop_w  = filling ? 20 : 45;
        if (r < 3)
            return ACT_CLEAR;
        else if (r < 5)
            return ACT_UNUSED;
        else if (r < 5 + push_w)
            return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else if (r < 5 + push_w + pop_w)
            return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
        else if (r < 85)
            return ACT_SEARCH;
        else
            return ACT_DELETE;
    endfunction

    task automatic test_directed_edges();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        // empty store
        send_request(ACT_POP_FRONT, 32'h0);
        send_request(ACT_POP_BACK, 32'h0);
        send_request(ACT_SEARCH, 32'h0);
        send_request(ACT_DELETE, 32'hFFFF_FFFF);
        send_request(ACT_UNUSED, 32'h1234_5678);
        // fill to the top with extremes and duplicates
        send_request(ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        for (int k = 0; k < DEPTH - 2; k++)
            send_request(k[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                         (k % 3 == 0) ? 32'h0 : ((k % 3 == 1) ? 32'hFFFF_FFFF : k));
        send_request(ACT_PUSH_FRONT, 32'h1);
        send_request(ACT_PUSH_BACK, 32'h2);
        send_request(ACT_SEARCH, 32'h7FFF_FFFF);
        send_request(ACT_SEARCH, 32'h0BAD_CAFE);
        send_request(ACT_DELETE, 32'h0);
        send_request(ACT_UNUSED, 32'h0);
        send_request(ACT_POP_FRONT, 32'h0);
        send_request(ACT_POP_BACK, 32'h0);
        send_request(ACT_CLEAR, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        bit filling;
        filling        = 1'b1;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            // bursts of 40 requests that mostly fill or mostly drain, chosen at random
            if (k % 40 == 0)
                filling = $urandom_range(1);
            send_request(pick_action(filling), pick_value());
        end
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_requested++;
        for (int k = 0; k < 48; k++)
            send_request(pick_action(1'b1), pick_value());
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic(360, 0, 0);
        test_random_traffic(360, 69, 0);
        test_output_hold_off();
        test_random_traffic(360, 0, 69);
        test_random_traffic(360, 20, 20);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
